>>> rtl/bdlp_pkg.sv
package bdlp_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned MsW   = 16;
	localparam int unsigned RegIdxW = 2;

	localparam logic [MsW-1:0] HighSettleRst = 16'd25;
	localparam logic [MsW-1:0] LowSettleRst  = 16'd50;
	localparam logic [MsW-1:0] LongPressRst  = 16'd1000;

	typedef enum logic [RegIdxW-1:0] {
		REG_HIGH_SETTLE = 2'd0,
		REG_LOW_SETTLE  = 2'd1,
		REG_LONG_PRESS  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_UNSTABLE   = 3'd0,
		PH_TIMER_LOW  = 3'd1,
		PH_TIMER_HIGH = 3'd2,
		PH_LOW        = 3'd3,
		PH_HIGH       = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		HS_NONE  = 2'd0,
		HS_PRESS = 2'd1,
		HS_LONG  = 2'd2
	} hold_t;

	typedef enum logic [2:0] {
		EV_UNSTABLE     = 3'd0,
		EV_PRESS_LOW    = 3'd1,
		EV_PRESSED_LONG = 3'd2,
		EV_HOLDING_LOW  = 3'd3,
		EV_IDLE_HIGH    = 3'd4,
		EV_RELEASED     = 3'd5,
		EV_PRESSED      = 3'd6,
		EV_INVALID      = 3'd7
	} event_t;

	typedef struct packed {
		logic [MsW-1:0] high_settle_ms;
		logic [MsW-1:0] low_settle_ms;
		logic [MsW-1:0] long_press_ms;
	} cfg_t;

endpackage

>>> rtl/bdlp_cfg.sv
module bdlp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [bdlp_pkg::RegIdxW-1:0]      wr_index,
	input  logic [bdlp_pkg::MsW-1:0]          wr_data,
	output bdlp_pkg::cfg_t                    cfg
);
	import bdlp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_settle_ms <= HighSettleRst;
			cfg_q.low_settle_ms  <= LowSettleRst;
			cfg_q.long_press_ms  <= LongPressRst;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HIGH_SETTLE: cfg_q.high_settle_ms <= wr_data;
				REG_LOW_SETTLE:  cfg_q.low_settle_ms  <= wr_data;
				REG_LONG_PRESS:  cfg_q.long_press_ms  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/bdlp_core.sv
module bdlp_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         level,
	input  logic [bdlp_pkg::TimeW-1:0]   now_ms,
	input  bdlp_pkg::cfg_t               cfg,
	output bdlp_pkg::event_t             ev
);
	import bdlp_pkg::*;

	logic             last_level_q, last_level_d;
	phase_t           phase_q, phase_d;
	hold_t            hold_q, hold_d;
	logic [TimeW-1:0] settle_start_q, settle_start_d;
	logic [TimeW-1:0] press_start_q, press_start_d;

	logic [TimeW-1:0] settle_age;
	logic [TimeW-1:0] press_age;
	logic             level_change;
	logic             high_done;
	logic             low_done;
	logic             long_due;

	// ages wrap modulo 2^32
	assign settle_age   = now_ms - settle_start_q;
	assign press_age    = now_ms - press_start_q;
	assign level_change = level != last_level_q;
	assign high_done    = settle_age >= {{(TimeW-MsW){1'b0}}, cfg.high_settle_ms};
	assign low_done     = settle_age >= {{(TimeW-MsW){1'b0}}, cfg.low_settle_ms};
	assign long_due     = (press_age > {{(TimeW-MsW){1'b0}}, cfg.long_press_ms})
		&& (hold_q != HS_LONG);

	always_comb begin
		last_level_d   = last_level_q;
		phase_d        = phase_q;
		hold_d         = hold_q;
		settle_start_d = settle_start_q;
		press_start_d  = press_start_q;
		if (level_change) begin
			last_level_d = level;
			phase_d      = PH_UNSTABLE;
		end else begin
			unique case (phase_q)
				PH_TIMER_HIGH: begin
					if (high_done) begin
						phase_d = PH_HIGH;
						hold_d  = HS_NONE;
					end
				end
				PH_TIMER_LOW: begin
					if (low_done) begin
						phase_d       = PH_LOW;
						press_start_d = now_ms;
						hold_d        = HS_PRESS;
					end
				end
				PH_LOW: begin
					if (long_due) begin
						hold_d = HS_LONG;
					end
				end
				PH_HIGH: ;
				default: begin
					phase_d        = level ? PH_TIMER_HIGH : PH_TIMER_LOW;
					settle_start_d = now_ms;
				end
			endcase
		end
	end

	always_comb begin
		ev = EV_UNSTABLE;
		if (!level_change) begin
			unique case (phase_q)
				PH_TIMER_HIGH: begin
					if (high_done) begin
						unique case (hold_q)
							HS_LONG:  ev = EV_RELEASED;
							HS_PRESS: ev = EV_PRESSED;
							default:  ev = EV_INVALID;
						endcase
					end
				end
				PH_TIMER_LOW: begin
					if (low_done) begin
						ev = EV_PRESS_LOW;
					end
				end
				PH_LOW: begin
					ev = long_due ? EV_PRESSED_LONG : EV_HOLDING_LOW;
				end
				PH_HIGH: begin
					ev = EV_IDLE_HIGH;
				end
				default: begin
					ev = EV_UNSTABLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q   <= 1'b1;
			phase_q        <= PH_UNSTABLE;
			hold_q         <= HS_NONE;
			settle_start_q <= '0;
			press_start_q  <= '0;
		end else if (step) begin
			last_level_q   <= last_level_d;
			phase_q        <= phase_d;
			hold_q         <= hold_d;
			settle_start_q <= settle_start_d;
			press_start_q  <= press_start_d;
		end
	end

endmodule

>>> rtl/button_debounce_long_press.sv
// channel  signals                                   width
// in       in_valid in_ready level now_ms            1, 32
// out      out_valid out_ready event_code            3
// cfg      cfg_valid cfg_ready cfg_index cfg_data    2, 16
//
// one item accepted per cycle while in_ready is high; its result becomes valid after
// the input register, then the result register after the state update
// cfg_ready is always high; a write takes effect on the next cycle
// reset returns thresholds to 25/50/1000 ms and the debouncer to unstable
// a stalled result holds the result register; the input register still
// takes one more item, and in_ready drops only when both are full
module button_debounce_long_press (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              level,
	input  logic [bdlp_pkg::TimeW-1:0]        now_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        event_code,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bdlp_pkg::RegIdxW-1:0]      cfg_index,
	input  logic [bdlp_pkg::MsW-1:0]          cfg_data
);
	import bdlp_pkg::*;

	logic             valid_s1;
	logic             level_s1;
	logic [TimeW-1:0] now_ms_s1;
	logic             out_valid_q;
	event_t           event_q;
	event_t           ev;
	cfg_t             cfg;
	logic             slot_free;
	logic             advance;

	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign advance   = valid_s1 && slot_free;
	assign in_ready  = !valid_s1 || slot_free;

	bdlp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bdlp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.level  (level_s1),
		.now_ms (now_ms_s1),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1  <= level;
			now_ms_s1 <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= ev;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = 3'(event_q);

endmodule
